// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the Jacobi stencil block.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define JSR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("jsr assertion failed");

// Clocked assertion that also holds during reset.
`define JSR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("jsr assertion failed");

`endif

// ===== sv/jsr_pkg.sv =====
// Package of the Jacobi stencil relaxation block: widths, reset values,
// register indexes and the flag struct shared by the front, queue and back.
// Depends on nothing.
`default_nettype none

package jsr_pkg;

    localparam int DEF_MAX_PADDED_WIDTH = 1024;
    localparam int DEF_SAMPLE_BITS      = 32;

    localparam int WEIGHT_BITS   = 32;
    localparam int WEIGHT_FRAC   = 30;
    localparam int IW_BITS       = 10;
    localparam int IH_BITS       = 16;
    // Padded row index; a grid may have 65537 padded rows.
    localparam int ROW_BITS      = 17;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QP_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QC_BITS     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_ADDR_BITS-1:0] REG_INTERIOR_WIDTH    = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_INTERIOR_HEIGHT   = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WEIGHT_VERTICAL   = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WEIGHT_HORIZONTAL = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WEIGHT_RHS        = 3'd4;

    localparam logic [IW_BITS-1:0]            RST_INTERIOR_WIDTH  = 10'd62;
    localparam logic [IH_BITS-1:0]            RST_INTERIOR_HEIGHT = 16'd62;
    localparam logic signed [WEIGHT_BITS-1:0] RST_WEIGHT_VERTICAL = 32'sd268435456;
    localparam logic signed [WEIGHT_BITS-1:0] RST_WEIGHT_HORIZ    = 32'sd268435456;
    localparam logic signed [WEIGHT_BITS-1:0] RST_WEIGHT_RHS      = -32'sd65536;

    // Control flags that travel with one stencil item between the parts.
    typedef struct packed {
        logic valid;
        logic last;
    } jsr_flags_t;

endpackage

`default_nettype wire

// ===== sv/jsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address collision. Depends on nothing.
`default_nettype none

module jsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/jsr_front.sv =====
// Front part: accepts padded grid samples, tracks the raster position, keeps
// the two line buffers and the neighbor window, and forms the stencil sums.
// Depends on jsr_pkg and jsr_ram.
`default_nettype none

module jsr_front import jsr_pkg::*; #(
    parameter int MAX_PADDED_WIDTH = DEF_MAX_PADDED_WIDTH,
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic signed [SAMPLE_BITS-1:0] x_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] rhs_sample,
    input  wire logic [IW_BITS-1:0]            interior_width,
    input  wire logic [IH_BITS-1:0]            interior_height,
    input  wire logic [QC_BITS-1:0]            q_count,
    output jsr_flags_t                         push,
    output logic signed [SAMPLE_BITS:0]        push_vsum,
    output logic signed [SAMPLE_BITS:0]        push_hsum,
    output logic signed [SAMPLE_BITS-1:0]      push_rhs
);

    localparam int CW      = $clog2(MAX_PADDED_WIDTH);
    localparam int PW_BITS = $clog2(MAX_PADDED_WIDTH + 1);

    logic                   fire;
    logic [PW_BITS-1:0]     pw;
    logic [ROW_BITS-1:0]    ph;
    logic [PW_BITS-1:0]     col_ext;
    logic                   emit;
    logic                   at_last;

    logic [CW-1:0]          col_reg, col_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;

    logic                   f2_valid_reg;
    logic                   f2_emit_reg;
    logic                   f2_last_reg;
    logic [CW-1:0]          f2_col_reg;
    logic [SAMPLE_BITS-1:0] f2_x_reg;
    logic [SAMPLE_BITS-1:0] f2_rhs_reg;

    logic [SAMPLE_BITS-1:0] top_rdata;
    logic [SAMPLE_BITS-1:0] mid_rdata;

    // Window: north source (upper row), east history, and previous sample.
    logic [SAMPLE_BITS-1:0] win_north_reg;
    logic [SAMPLE_BITS-1:0] win_mid0_reg;
    logic [SAMPLE_BITS-1:0] win_mid1_reg;
    logic [SAMPLE_BITS-1:0] win_prev_reg;

    // One slot is kept for the item in the read stage, so a push always fits.
    assign s_tready = ((QC_BITS+1)'(q_count) + (QC_BITS+1)'(f2_valid_reg))
                      < (QC_BITS+1)'(QUEUE_DEPTH);
    assign fire     = s_tvalid && s_tready;

    // Padded sizes with out-of-range register values folded in.
    always_comb
    begin
        if (interior_width == '0)
        begin
            pw = PW_BITS'(3);
        end
        else if (32'(interior_width) > 32'(MAX_PADDED_WIDTH - 2))
        begin
            pw = PW_BITS'(MAX_PADDED_WIDTH);
        end
        else
        begin
            pw = PW_BITS'(interior_width) + PW_BITS'(2);
        end
        if (interior_height == '0)
        begin
            ph = ROW_BITS'(3);
        end
        else
        begin
            ph = ROW_BITS'(interior_height) + ROW_BITS'(2);
        end
    end

    assign col_ext = PW_BITS'(col_reg);
    assign emit    = (row_reg >= ROW_BITS'(2)) && (col_ext >= PW_BITS'(2)) &&
                     (row_reg < ph) && (col_ext < pw);
    assign at_last = (row_reg == ph - ROW_BITS'(1)) && (col_ext == pw - PW_BITS'(1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if ((PW_BITS+1)'(col_ext) + (PW_BITS+1)'(1) >= (PW_BITS+1)'(pw))
        begin
            col_next = '0;
            if ((ROW_BITS+1)'(row_reg) + (ROW_BITS+1)'(1) >= (ROW_BITS+1)'(ph))
            begin
                row_next = '0;
            end
            else
            begin
                row_next = row_reg + ROW_BITS'(1);
            end
        end
        else
        begin
            col_next = CW'(col_ext + PW_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            f2_valid_reg <= fire;
            if (fire)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            f2_emit_reg <= emit;
            f2_last_reg <= at_last;
            f2_col_reg  <= col_reg;
            f2_x_reg    <= x_sample;
            f2_rhs_reg  <= rhs_sample;
        end
    end

    // Upper line buffer takes the middle row's old entry in the cycle after its read.
    jsr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_PADDED_WIDTH)
    ) u_upper (
        .clk   (clk),
        .we    (f2_valid_reg),
        .waddr (f2_col_reg),
        .wdata (mid_rdata),
        .raddr (col_reg),
        .rdata (top_rdata)
    );

    jsr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_PADDED_WIDTH)
    ) u_middle (
        .clk   (clk),
        .we    (fire),
        .waddr (col_reg),
        .wdata (x_sample),
        .raddr (col_reg),
        .rdata (mid_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_north_reg <= '0;
            win_mid0_reg  <= '0;
            win_mid1_reg  <= '0;
            win_prev_reg  <= '0;
        end
        else if (f2_valid_reg)
        begin
            win_north_reg <= top_rdata;
            win_mid1_reg  <= win_mid0_reg;
            win_mid0_reg  <= mid_rdata;
            win_prev_reg  <= f2_x_reg;
        end
    end

    assign push.valid = f2_valid_reg && f2_emit_reg;
    assign push.last  = f2_last_reg;
    assign push_vsum  = (SAMPLE_BITS+1)'($signed(win_north_reg)) +
                        (SAMPLE_BITS+1)'($signed(win_prev_reg));
    assign push_hsum  = (SAMPLE_BITS+1)'($signed(mid_rdata)) +
                        (SAMPLE_BITS+1)'($signed(win_mid1_reg));
    assign push_rhs   = $signed(f2_rhs_reg);

endmodule

`default_nettype wire

// ===== sv/jsr_queue.sv =====
// Short queue between the front and the back of the stencil block.
// Depends on jsr_pkg.
`default_nettype none

module jsr_queue import jsr_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire jsr_flags_t                    push,
    input  wire logic signed [SAMPLE_BITS:0]   push_vsum,
    input  wire logic signed [SAMPLE_BITS:0]   push_hsum,
    input  wire logic signed [SAMPLE_BITS-1:0] push_rhs,
    input  wire logic                          pop,
    output jsr_flags_t                         head,
    output logic signed [SAMPLE_BITS:0]        head_vsum,
    output logic signed [SAMPLE_BITS:0]        head_hsum,
    output logic signed [SAMPLE_BITS-1:0]      head_rhs,
    output logic [QC_BITS-1:0]                 count
);

    logic [SAMPLE_BITS:0]   vsum_mem [QUEUE_DEPTH];
    logic [SAMPLE_BITS:0]   hsum_mem [QUEUE_DEPTH];
    logic [SAMPLE_BITS-1:0] rhs_mem  [QUEUE_DEPTH];
    logic                   last_mem [QUEUE_DEPTH];

    logic [QP_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QC_BITS-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + QC_BITS'(1);
        end
        else if (!push.valid && pop)
        begin
            count_next = count_reg - QC_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QP_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QP_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            vsum_mem[wr_ptr_reg] <= push_vsum;
            hsum_mem[wr_ptr_reg] <= push_hsum;
            rhs_mem[wr_ptr_reg]  <= push_rhs;
            last_mem[wr_ptr_reg] <= push.last;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.last  = last_mem[rd_ptr_reg];
    assign head_vsum  = $signed(vsum_mem[rd_ptr_reg]);
    assign head_hsum  = $signed(hsum_mem[rd_ptr_reg]);
    assign head_rhs   = $signed(rhs_mem[rd_ptr_reg]);
    assign count      = count_reg;

endmodule

`default_nettype wire

// ===== sv/jsr_back.sv =====
// Back part: weights the stencil sums, adds and rounds them, and saturates
// the result into the output register. Depends on jsr_pkg.
`default_nettype none

module jsr_back import jsr_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire jsr_flags_t                    head,
    input  wire logic signed [SAMPLE_BITS:0]   head_vsum,
    input  wire logic signed [SAMPLE_BITS:0]   head_hsum,
    input  wire logic signed [SAMPLE_BITS-1:0] head_rhs,
    input  wire logic signed [WEIGHT_BITS-1:0] weight_vertical,
    input  wire logic signed [WEIGHT_BITS-1:0] weight_horizontal,
    input  wire logic signed [WEIGHT_BITS-1:0] weight_rhs,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [SAMPLE_BITS-1:0]             new_value,
    output logic                               saturated,
    output logic                               last
);

    localparam int PS_W  = SAMPLE_BITS + 1 + WEIGHT_BITS;
    localparam int PR_W  = SAMPLE_BITS + WEIGHT_BITS;
    localparam int SUM_W = PS_W + 2;
    localparam int SH_W  = SUM_W - WEIGHT_FRAC;
    localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) <<< (WEIGHT_FRAC - 1);
    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                    advance;

    logic                    m_valid_reg, m_last_reg;
    logic signed [PS_W-1:0]  prod_v_reg, prod_h_reg;
    logic signed [PR_W-1:0]  prod_r_reg;

    logic                    s_valid_reg, s_last_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;

    logic [SH_W-1:0]         shifted;
    logic [SH_W-SAMPLE_BITS:0] top_bits;
    logic                    in_range;
    logic [SAMPLE_BITS-1:0]  value_next;

    logic                    out_valid_reg, out_last_reg, out_sat_reg;
    logic [SAMPLE_BITS-1:0]  out_value_reg;

    // The whole back pipeline moves together when the output can move.
    assign advance = !out_valid_reg || m_tready;
    assign pop     = advance && head.valid;

    assign sum_next = SUM_W'(prod_v_reg) + SUM_W'(prod_h_reg) +
                      SUM_W'(prod_r_reg) + ROUND;

    assign shifted  = sum_reg[SUM_W-1:WEIGHT_FRAC];
    assign top_bits = shifted[SH_W-1:SAMPLE_BITS-1];
    assign in_range = (&top_bits) || !(|top_bits);

    always_comb
    begin
        if (in_range)
        begin
            value_next = shifted[SAMPLE_BITS-1:0];
        end
        else if (shifted[SH_W-1])
        begin
            value_next = SAT_MIN;
        end
        else
        begin
            value_next = SAT_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg   <= head.valid;
            s_valid_reg   <= m_valid_reg;
            out_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_last_reg    <= head.last;
            prod_v_reg    <= PS_W'(head_vsum) * PS_W'(weight_vertical);
            prod_h_reg    <= PS_W'(head_hsum) * PS_W'(weight_horizontal);
            prod_r_reg    <= PR_W'(head_rhs) * PR_W'(weight_rhs);
            s_last_reg    <= m_last_reg;
            sum_reg       <= sum_next;
            out_last_reg  <= s_last_reg;
            out_value_reg <= value_next;
            out_sat_reg   <= !in_range;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign new_value = out_value_reg;
    assign saturated = out_sat_reg;
    assign last      = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/jacobi_stencil_relaxation.sv =====
// Top level of the Jacobi stencil relaxation block: configuration registers
// and the front, queue and back parts. Depends on jsr_pkg, jsr_front,
// jsr_queue and jsr_back.
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid / s_tready  s_tdata: x_sample, rhs_sample
//  m_*       out        m_tvalid / m_tready  m_tdata: new_value; m_tuser: saturated;
//                                            m_tlast: last
//  cfg_*     in         cfg_wr_en            cfg_addr, cfg_wdata
//
// One padded grid sample is taken per clock while s_tready is high. After the
// transfer that completes its interior point, a result passes the line-buffer
// read, the queue, the multiply stage and the sum stage to the output register.
// Reset clears the position counters, the window and all valid flags; line-buffer
// entries read before they are written feed only taps no interior point uses.
// On an output stall s_tready falls once the queue and read stage hold QUEUE_DEPTH items.
`default_nettype none

module jacobi_stencil_relaxation import jsr_pkg::*; #(
    parameter int MAX_PADDED_WIDTH = DEF_MAX_PADDED_WIDTH,
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
    localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0 up: x_sample, rhs_sample, zero fill.
    input  wire logic [IN_W-1:0]          s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // Fields from bit 0 up: new_value, zero fill.
    output logic [OUT_W-1:0]              m_tdata,
    // Fields from bit 0 up: saturated.
    output logic [0:0]                    m_tuser,
    output logic                          m_tlast
);

    logic [IW_BITS-1:0]            width_reg;
    logic [IH_BITS-1:0]            height_reg;
    logic signed [WEIGHT_BITS-1:0] wv_reg, wh_reg, wr_reg;

    jsr_flags_t                    push, head;
    logic signed [SAMPLE_BITS:0]   push_vsum, push_hsum, head_vsum, head_hsum;
    logic signed [SAMPLE_BITS-1:0] push_rhs, head_rhs;
    logic [QC_BITS-1:0]            q_count;
    logic                          pop;
    logic [SAMPLE_BITS-1:0]        new_value;
    logic                          saturated;

    // Configuration writes land directly; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_INTERIOR_WIDTH;
            height_reg <= RST_INTERIOR_HEIGHT;
            wv_reg     <= RST_WEIGHT_VERTICAL;
            wh_reg     <= RST_WEIGHT_HORIZ;
            wr_reg     <= RST_WEIGHT_RHS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_INTERIOR_WIDTH:    width_reg  <= cfg_wdata[IW_BITS-1:0];
                REG_INTERIOR_HEIGHT:   height_reg <= cfg_wdata[IH_BITS-1:0];
                REG_WEIGHT_VERTICAL:   wv_reg     <= $signed(cfg_wdata[WEIGHT_BITS-1:0]);
                REG_WEIGHT_HORIZONTAL: wh_reg     <= $signed(cfg_wdata[WEIGHT_BITS-1:0]);
                REG_WEIGHT_RHS:        wr_reg     <= $signed(cfg_wdata[WEIGHT_BITS-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    jsr_front #(
        .MAX_PADDED_WIDTH (MAX_PADDED_WIDTH),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .x_sample        ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .rhs_sample      ($signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
        .interior_width  (width_reg),
        .interior_height (height_reg),
        .q_count         (q_count),
        .push            (push),
        .push_vsum       (push_vsum),
        .push_hsum       (push_hsum),
        .push_rhs        (push_rhs)
    );

    jsr_queue #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_vsum (push_vsum),
        .push_hsum (push_hsum),
        .push_rhs  (push_rhs),
        .pop       (pop),
        .head      (head),
        .head_vsum (head_vsum),
        .head_hsum (head_hsum),
        .head_rhs  (head_rhs),
        .count     (q_count)
    );

    jsr_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .head_vsum         (head_vsum),
        .head_hsum         (head_hsum),
        .head_rhs          (head_rhs),
        .weight_vertical   (wv_reg),
        .weight_horizontal (wh_reg),
        .weight_rhs        (wr_reg),
        .pop               (pop),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .new_value         (new_value),
        .saturated         (saturated),
        .last              (m_tlast)
    );

    assign m_tdata    = OUT_W'(new_value);
    assign m_tuser[0] = saturated;

endmodule

`default_nettype wire

// ===== sv/jsr_checker.sv =====
// Port-level checker for the Jacobi stencil relaxation block, bound to the
// top level. Depends on jsr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module jsr_checker import jsr_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic [0:0]       m_tuser,
    input wire logic             m_tlast
);

    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // A stalled result keeps its value and its frame mark.
    `JSR_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // A clipped result sits at one of the two rails.
    `JSR_ASSERT(a_sat_rail, clk, rst_n, m_tvalid && m_tuser[0] |-> (m_tdata[SAMPLE_BITS-1:0] == SAT_MAX) || (m_tdata[SAMPLE_BITS-1:0] == SAT_MIN))

    // Once reset has been seen at a clock edge, no result is offered at the next one.
    `JSR_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !m_tvalid)

endmodule

bind jacobi_stencil_relaxation jsr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_jsr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== verif/jacobi_stencil_relaxation_tb.sv =====
// Self-checking testbench for the Jacobi stencil relaxation block: streams padded grids
// through it and checks every interior result against a cycle-free predictor or a
// result typed into a directed row. Depends on jsr_pkg and jacobi_stencil_relaxation.

module testbench;
    import jsr_pkg::*;

    // Run limits.
    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned RANDOM_ITEMS  = 1250;
    localparam int unsigned MAX_PW        = DEF_MAX_PADDED_WIDTH;

    localparam logic [31:0] S_MAX = 32'h7fff_ffff;
    localparam logic [31:0] S_MIN = 32'h8000_0000;
    localparam logic [31:0] W_ONE = 32'h4000_0000;   // 1.0 in Q2.30

    // One interior result as the master side carries it.
    typedef struct packed {
        logic [31:0] value;
        logic        sat;
        logic        last;
    } relaxed_t;

    // How a directed row is checked: by the predictor, as a row that must cause
    // nothing, or against a result typed into the table.
    typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_TYPED} check_kind_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] rhs;
        check_kind_t kind;
        relaxed_t    result;
    } stim_row_t;

    // Receiver stall patterns; each runs for a random number of cycles.
    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // Fields from bit 0 up: x_sample, rhs_sample.
    logic [63:0]              s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // Fields from bit 0 up: new_value.
    logic [31:0]              m_tdata;
    // Fields from bit 0 up: saturated.
    logic [0:0]               m_tuser;
    logic                     m_tlast;

    jacobi_stencil_relaxation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: the configuration as last written, the two line
    // buffers, the six window taps and the padded position of the next sample.
    // ------------------------------------------------------------------
    logic [IW_BITS-1:0] cfg_width  = RST_INTERIOR_WIDTH;
    logic [IH_BITS-1:0] cfg_height = RST_INTERIOR_HEIGHT;
    logic [31:0]        w_vert     = RST_WEIGHT_VERTICAL;
    logic [31:0]        w_horiz    = RST_WEIGHT_HORIZ;
    logic [31:0]        w_rhs      = RST_WEIGHT_RHS;

    logic [31:0] line_upper  [MAX_PW];
    logic [31:0] line_middle [MAX_PW];
    logic [31:0] taps [6];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;

    relaxed_t  expected_q [$];   // interior results still owed by the block
    stim_row_t typed_q [$];      // directed rows, one per item, in send order

    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    bit          tx_quiet    = 1'b0;
    bit          rx_quiet    = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned hold_left   = 0;
    rx_pattern_t rx_mode     = RX_STEADY;
    int unsigned rx_mode_left = 0;

    stim_row_t directed_rows [18];

    // Sizes clamp the way the block does: zero acts as one, and the width
    // cannot exceed what the line buffers hold.
    function automatic int unsigned padded_width();
        int unsigned w;
        w = cfg_width;
        if (w == 0)
            w = 1;
        if (w > MAX_PW - 2)
            w = MAX_PW - 2;
        return w + 2;
    endfunction

    function automatic int unsigned padded_height();
        int unsigned h;
        h = cfg_height;
        if (h == 0)
            h = 1;
        return h + 2;
    endfunction

    // Items from the current position to the end of the grid. Only valid while
    // the block is idle and the row has not run past the height.
    function automatic int unsigned items_left_in_grid();
        return padded_width() * padded_height() - (row_pos * padded_width() + col_pos);
    endfunction

    // Advances the stencil by one padded sample. Returns 1 and the expected
    // result when the sample completes an interior point.
    function automatic bit relax_step(input logic [31:0] x, input logic [31:0] rhs,
                                      output relaxed_t res);
        int unsigned pw;
        int unsigned ph;
        int unsigned c;
        int unsigned r;
        logic [31:0] top_in;
        logic [31:0] mid_in;
        logic [31:0] south;
        logic signed [32:0] vsum;
        logic signed [32:0] hsum;
        logic signed [79:0] acc;
        logic signed [79:0] shifted;
        bit made;
        pw = padded_width();
        ph = padded_height();
        c = col_pos;
        r = row_pos;
        made = 1'b0;
        res = '0;

        top_in = line_upper[c];
        mid_in = line_middle[c];
        line_upper[c] = mid_in;
        line_middle[c] = x;

        // Taps: upper c, upper c-1, middle c, middle c-1, middle c-2, previous
        // sample of this row (the south neighbour of the point being finished).
        taps[1] = taps[0];
        taps[0] = top_in;
        taps[4] = taps[3];
        taps[3] = taps[2];
        taps[2] = mid_in;
        south = taps[5];
        taps[5] = x;

        if (r >= 2 && c >= 2 && r < ph && c < pw) begin
            vsum = $signed(taps[1]) + $signed(south);
            hsum = $signed(taps[2]) + $signed(taps[4]);
            // Exact sum of the three products, then round half up into Q16.16.
            acc = vsum * $signed(w_vert) + hsum * $signed(w_horiz)
                + $signed(rhs) * $signed(w_rhs) + (80'sd1 <<< 29);
            shifted = acc >>> 30;
            if (shifted > 80'sd2147483647) begin
                res.value = S_MAX;
                res.sat = 1'b1;
            end
            else if (shifted < -80'sd2147483648) begin
                res.value = S_MIN;
                res.sat = 1'b1;
            end
            else begin
                res.value = shifted[31:0];
            end
            res.last = (r == ph - 1) && (c == pw - 1);
            made = 1'b1;
        end

        if (c + 1 >= pw) begin
            col_pos = 0;
            row_pos = (r + 1 >= ph) ? 0 : r + 1;
        end
        else begin
            col_pos = c + 1;
        end
        return made;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (mismatches < 40)
            $display("mismatch: %s at cycle %0d, got %h, expected %h",
                     what, cycle_count, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, check an output transfer against the
    // oldest expectation, then feed an input transfer to the predictor.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        relaxed_t  want;
        relaxed_t  pred;
        stim_row_t row;
        bit        made;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report("result with none expected", m_tdata, '0);
                end
                else begin
                    want = expected_q.pop_front();
                    if (m_tdata !== want.value)
                        report("new_value", m_tdata, want.value);
                    if (m_tuser[0] !== want.sat)
                        report("saturated", {31'd0, m_tuser[0]}, {31'd0, want.sat});
                    if (m_tlast !== want.last)
                        report("last", {31'd0, m_tlast}, {31'd0, want.last});
                end
            end
            if (s_tvalid && s_tready) begin
                made = relax_step(s_tdata[31:0], s_tdata[63:32], pred);
                if (typed_q.size() != 0) begin
                    row = typed_q.pop_front();
                    case (row.kind)
                        CHECK_TYPED: expected_q.push_back(row.result);
                        CHECK_NONE:  ;
                        default:     if (made) expected_q.push_back(pred);
                    endcase
                end
                else if (made) begin
                    expected_q.push_back(pred);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: m_tready changes at the falling edge. A requested hold keeps
    // it low for HOLD_CYCLES so the block backs up and drops s_tready.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (rx_mode_left == 0) begin
            rx_mode = rx_pattern_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(10, 150);
        end
        else begin
            rx_mode_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (rx_quiet) begin
            m_tready <= 1'b1;
        end
        else begin
            case (rx_mode)
                RX_STEADY:   m_tready <= 1'b1;
                RX_COIN:     m_tready <= $urandom_range(0, 1);
                RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                default:     m_tready <= (rx_mode_left % 3 != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender and configuration tasks. Inputs change only at the falling edge.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_INTERIOR_WIDTH:    cfg_width = value[IW_BITS-1:0];
            REG_INTERIOR_HEIGHT:   cfg_height = value[IH_BITS-1:0];
            REG_WEIGHT_VERTICAL:   w_vert = value;
            REG_WEIGHT_HORIZONTAL: w_horiz = value;
            REG_WEIGHT_RHS:        w_rhs = value;
            default:               ;
        endcase
    endtask

    // Offers one item and returns after its transfer. Outside quiet stretches
    // the sender works in bursts with short gaps between them.
    task automatic send_item(input logic [31:0] x, input logic [31:0] rhs);
        int unsigned gap;
        if (!tx_quiet) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {rhs, x};
        do @(posedge clk); while (!s_tready);
    endtask

    // Pauses the sender until every expected result has arrived, then lets
    // results-free items still in flight pass before anything is reconfigured.
    task automatic wait_drained();
        int unsigned n;
        @(negedge clk);
        s_tvalid <= 1'b0;
        for (n = 0; n < DRAIN_LIMIT && expected_q.size() != 0; n++)
            @(negedge clk);
        if (expected_q.size() != 0) begin
            report("results never delivered", expected_q.size(), '0);
            expected_q.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Samples lean toward small Q16.16 values, with full-range values and the
    // extremes mixed in so every bit toggles and saturation happens often.
    function automatic logic [31:0] next_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2, 3, 4: return $urandom();
            default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [31:0] next_weight(input bit for_rhs);
        case ($urandom_range(0, 6))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3, 4:    return $urandom();
            default: return for_rhs ? 32'd0 - $urandom_range(1, 32'h0040_0000)
                                    : $urandom_range(0, 32'h2000_0000);
        endcase
    endfunction

    task automatic write_weights();
        write_reg(REG_WEIGHT_VERTICAL, next_weight(1'b0));
        write_reg(REG_WEIGHT_HORIZONTAL, next_weight(1'b0));
        write_reg(REG_WEIGHT_RHS, next_weight(1'b1));
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) send_item(next_sample(), next_sample());
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int unsigned phase;
        int unsigned random_items;
        int unsigned grid_items;
        int unsigned first_part;
        int unsigned grids;
        int unsigned i;

        foreach (line_upper[k])
            line_upper[k] = '0;
        foreach (line_middle[k])
            line_middle[k] = '0;
        foreach (taps[k])
            taps[k] = '0;

        // Two 1x1 interior grids back to back (the second tests the position
        // wrap). Only the single interior point of each produces a result. Its
        // north and south are border samples, which are used as they arrive;
        // the centre sample is never part of its own update. With the vertical and
        // horizontal weights at their extremes both results clip, one high and one low.
        directed_rows = '{
            '{32'h0,        S_MIN, CHECK_NONE,  '0},
            '{S_MAX,        S_MIN, CHECK_NONE,  '0},   // north
            '{32'h0,        S_MIN, CHECK_NONE,  '0},
            '{32'h0,        S_MAX, CHECK_NONE,  '0},   // west
            '{32'h1234_5678, S_MAX, CHECK_NONE, '0},   // centre
            '{32'h0,        S_MAX, CHECK_NONE,  '0},   // east
            '{32'h0,        S_MIN, CHECK_NONE,  '0},
            '{S_MAX,        S_MIN, CHECK_NONE,  '0},   // south
            '{32'h0,        32'h0, CHECK_TYPED, '{S_MAX, 1'b1, 1'b1}},
            '{32'hffff_ffff, 32'h0, CHECK_NONE, '0},
            '{32'h0,        32'h0, CHECK_NONE,  '0},   // north
            '{32'hffff_ffff, 32'h0, CHECK_NONE, '0},
            '{S_MAX,        32'h0, CHECK_NONE,  '0},   // west
            '{32'hffff_ffff, 32'h0, CHECK_NONE, '0},   // centre
            '{S_MAX,        32'h0, CHECK_NONE,  '0},   // east
            '{32'h0,        32'h0, CHECK_NONE,  '0},
            '{32'h0,        32'h0, CHECK_NONE,  '0},   // south
            '{S_MAX,        S_MIN, CHECK_TYPED, '{S_MIN, 1'b1, 1'b1}}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Zero sizes act as one interior column and one interior row.
        write_reg(REG_INTERIOR_WIDTH, 32'd0);
        write_reg(REG_INTERIOR_HEIGHT, 32'd0);
        write_reg(REG_WEIGHT_VERTICAL, S_MAX);
        write_reg(REG_WEIGHT_HORIZONTAL, S_MIN);
        write_reg(REG_WEIGHT_RHS, W_ONE);
        for (i = 0; i < 18; i++) begin
            typed_q.push_back(directed_rows[i]);
            send_item(directed_rows[i].x, directed_rows[i].rhs);
        end
        wait_drained();

        // Random phases: new sizes and weights, then one to three whole grids.
        // Phase 1 holds the receiver off while the sender streams without gaps;
        // phase 3 stops mid-grid, drains, rewrites weights and keeps or raises the height.
        phase = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0:       write_reg(REG_INTERIOR_WIDTH, 32'd0);
                1:       write_reg(REG_INTERIOR_WIDTH, $urandom_range(9, 40));
                default: write_reg(REG_INTERIOR_WIDTH, $urandom_range(1, 8));
            endcase
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_INTERIOR_HEIGHT, 32'd0);
            else
                write_reg(REG_INTERIOR_HEIGHT, $urandom_range(1, 6));
            write_weights();
            grid_items = items_left_in_grid();
            grids = $urandom_range(1, 3);

            if (phase == 1) begin
                write_reg(REG_INTERIOR_WIDTH, 32'd10);
                write_reg(REG_INTERIOR_HEIGHT, 32'd10);
                grid_items = items_left_in_grid();
                grids = 1;
                tx_quiet = 1'b1;
                hold_request = 1'b1;
                send_random(grid_items);
                random_items += grid_items;
            end
            else if (phase == 3) begin
                first_part = $urandom_range(1, grid_items - 1);
                send_random(first_part);
                wait_drained();
                write_weights();
                write_reg(REG_INTERIOR_HEIGHT, padded_height() - 2 + $urandom_range(0, 3));
                grid_items = items_left_in_grid();
                send_random(grid_items);
                random_items += first_part + grid_items;
            end
            else begin
                send_random(grids * grid_items);
                random_items += grids * grid_items;
            end
            wait_drained();
            phase++;
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/jsr_pkg.sv
sv/jsr_ram.sv
sv/jsr_front.sv
sv/jsr_queue.sv
sv/jsr_back.sv
sv/jacobi_stencil_relaxation.sv
sv/jsr_checker.sv
verif/jacobi_stencil_relaxation_tb.sv
